>>> hw/rtl/dbtri_pkg.sv
// ----------------------------------------------------------------------------
// dbtri_pkg
// Shared types, codes and constants of the day-bucketed time range index.
// ----------------------------------------------------------------------------
package dbtri_pkg;

  localparam int unsigned TS_W        = 31;
  localparam int unsigned IDX_W       = 13;
  localparam int unsigned DAY_VW      = 15;
  localparam int unsigned REM_W       = 17;
  localparam int unsigned CMP_W       = 17;
  localparam int unsigned RECIP_SHIFT = 47;

  localparam logic [REM_W-1:0] SECS_PER_DAY = 17'd86400;
  // floor(2^47 / 86400): quotient estimate is exact or one low
  localparam logic [TS_W-1:0]  DAY_RECIP    = 31'd1628906115;

  typedef enum logic [0:0] {
    OPC_LOAD  = 1'b0,
    OPC_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_STORE_OVF = 2'd1,
    ST_DAY_OVF   = 2'd2,
    ST_NOT_BUILT = 2'd3
  } status_e;

  typedef struct packed {
    logic            opcode;
    logic [TS_W-1:0] timestamp;
    logic            last_of_load;
    logic [TS_W-1:0] range_start;
    logic [TS_W-1:0] range_stop;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] start_index;
    logic [IDX_W-1:0] stop_index;
    logic [1:0]       status;
  } out_word_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_APPEND,
    DP_BLD_CHECK,
    DP_FD,
    DP_LD,
    DP_LATCH_DAY,
    DP_FWD_FETCH,
    DP_FWD_STEP,
    DP_FWD_FILL,
    DP_REV_FETCH,
    DP_REV_STEP,
    DP_REV_FILL,
    DP_DENY,
    DP_QS_DIV,
    DP_QS_DEC,
    DP_QS_LO,
    DP_QS_HI,
    DP_QS_SCAN,
    DP_QS_CMP,
    DP_QP_DIV,
    DP_QP_DEC,
    DP_QP_HI,
    DP_QP_LO,
    DP_QP_SCAN,
    DP_QP_CMP,
    DP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic is_last;
    logic built;
    logic bad_store;
    logic day_valid;
    logic days_bad;
    logic fwd_hit;
    logic rev_hit;
    logic i_last;
    logic i_first;
    logic k_full;
    logic k_zero;
    logic qs_low;
    logic qs_high;
    logic qp_low;
    logic qp_high;
    logic r_zero;
    logic b_zero;
    logic scan_go;
    logic ts_ge;
    logic p_go;
    logic j_in;
    logic ts_le;
  } dp_stat_t;

endpackage

>>> hw/rtl/dbtri_day_div.sv
// ----------------------------------------------------------------------------
// dbtri_day_div
// Three-stage divide of a seconds value by 86400: day number and remainder.
// ----------------------------------------------------------------------------
module dbtri_day_div import dbtri_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [TS_W-1:0]   time_i,
  output logic              valid_o,
  output logic [DAY_VW-1:0] day_o,
  output logic [REM_W-1:0]  rem_o
);

  logic [2*TS_W-1:0] prod_q;
  logic [TS_W-1:0]   t1_q, t2_q, qm_q, r0;
  logic [DAY_VW-1:0] q0, q0_q, day_q;
  logic [REM_W-1:0]  rem_q;
  logic              v1_q, v2_q, v3_q;

  assign q0 = prod_q[RECIP_SHIFT +: DAY_VW];
  assign r0 = t2_q - qm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= (2*TS_W)'(time_i) * (2*TS_W)'(DAY_RECIP);
    t1_q   <= time_i;
    q0_q   <= q0;
    qm_q   <= TS_W'(q0) * TS_W'(SECS_PER_DAY);
    t2_q   <= t1_q;
    // correct the estimate by at most one day
    if (r0 >= TS_W'(SECS_PER_DAY)) begin
      day_q <= q0_q + DAY_VW'(1);
      rem_q <= REM_W'(r0 - TS_W'(SECS_PER_DAY));
    end else begin
      day_q <= q0_q;
      rem_q <= REM_W'(r0);
    end
  end

  assign valid_o = v3_q;
  assign day_o   = day_q;
  assign rem_o   = rem_q;

endmodule

>>> hw/rtl/dbtri_datapath.sv
// ----------------------------------------------------------------------------
// dbtri_datapath
// Time store, day tables, day divider, counters and result register.
// ----------------------------------------------------------------------------
module dbtri_datapath import dbtri_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 4096,
  parameter int unsigned MAX_DAYS    = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dp_cmd_t   cmd_i,
  input  in_word_t  in_word_i,
  output dp_stat_t  stat_o,
  output out_word_t out_word_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned AW    = $clog2(MAX_ENTRIES);
  localparam int unsigned DW    = $clog2(MAX_DAYS + 1);
  localparam int unsigned DAW   = (MAX_DAYS > 1) ? $clog2(MAX_DAYS) : 1;

  dp_op_e op;

  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_eff, i_q, i_d, j_q, j_d;
  logic [CNT_W-1:0] lo_q, lo_d, hi_q, hi_d, start_q, start_d, stop_q, stop_d;
  logic [CNT_W-1:0] st_ra_full, first_rd, end_rd, ft_wd, et_wd;
  logic [DW-1:0]    span_q, span_d, k_q, k_d, b_q, b_d, b_clamp, b_p1, b_m1, k_m1;
  logic [DAY_VW-1:0] fd_q, fd_d, d_q, d_d, dsub;
  logic             r_zero_q, r_zero_d;
  logic [1:0]       status_q, status_d;
  in_word_t         word_q, word_d;
  out_word_t        out_q, out_d;
  logic             load_open_q, load_open_d, ovf_q, ovf_d, built_q, built_d;
  logic             fetch_q, fetch_d;
  logic             has_room, bad_store, days_bad, fwd_hit, rev_hit;

  logic [CMP_W-1:0] d_x, fd_x, k_x, span_x, dsub_x, dv_x;

  logic              div_v, div_valid;
  logic [TS_W-1:0]   div_t;
  logic [DAY_VW-1:0] div_day;
  logic [REM_W-1:0]  div_rem;

  logic [TS_W-1:0]  store_mem [MAX_ENTRIES];
  logic [CNT_W-1:0] first_mem [MAX_DAYS];
  logic [CNT_W-1:0] end_mem   [MAX_DAYS];
  logic [TS_W-1:0]  store_rd;
  logic             st_we, ft_we, et_we;
  logic [AW-1:0]    st_wa, st_ra;
  logic [DAW-1:0]   ft_wa, ft_ra, et_wa, et_ra;

  assign op = cmd_i.op;

  // day divider, fed from the store read port or from a query bound
  assign div_v = fetch_q || (op == DP_QS_DIV) || (op == DP_QP_DIV);
  assign div_t = fetch_q ? store_rd :
                 ((op == DP_QS_DIV) ? word_q.range_start : word_q.range_stop);

  dbtri_day_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_v),
    .time_i  (div_t),
    .valid_o (div_valid),
    .day_o   (div_day),
    .rem_o   (div_rem)
  );

  assign d_x    = CMP_W'(d_q);
  assign fd_x   = CMP_W'(fd_q);
  assign k_x    = CMP_W'(k_q);
  assign span_x = CMP_W'(span_q);
  assign dsub   = d_q - fd_q;
  assign dsub_x = CMP_W'(dsub);
  assign dv_x   = CMP_W'(div_day);

  assign cnt_eff   = load_open_q ? cnt_q : '0;
  assign has_room  = cnt_eff < CNT_W'(MAX_ENTRIES);
  assign bad_store = ovf_q || (cnt_q == '0);
  assign days_bad  = (dv_x < fd_x) || ((dv_x - fd_x + CMP_W'(1)) > CMP_W'(MAX_DAYS));
  assign fwd_hit   = (k_q < span_q) && (d_x >= fd_x + k_x);
  assign rev_hit   = (k_q != '0) && (d_x + CMP_W'(1) <= fd_x + k_x);
  assign b_clamp   = (dsub_x > span_x - CMP_W'(1)) ? span_q - DW'(1) : DW'(dsub);
  assign b_p1      = b_q + DW'(1);
  assign b_m1      = b_q - DW'(1);
  assign k_m1      = k_q - DW'(1);

  assign stat_o.is_query  = (word_q.opcode == OPC_QUERY);
  assign stat_o.is_last   = word_q.last_of_load;
  assign stat_o.built     = built_q;
  assign stat_o.bad_store = bad_store;
  assign stat_o.day_valid = div_valid;
  assign stat_o.days_bad  = days_bad;
  assign stat_o.fwd_hit   = fwd_hit;
  assign stat_o.rev_hit   = rev_hit;
  assign stat_o.i_last    = (i_q + CNT_W'(1)) == cnt_q;
  assign stat_o.i_first   = (i_q == CNT_W'(1));
  assign stat_o.k_full    = (k_q >= span_q);
  assign stat_o.k_zero    = (k_q == '0);
  assign stat_o.qs_low    = (d_q < fd_q);
  assign stat_o.qs_high   = (dsub_x >= span_x);
  assign stat_o.qp_low    = (d_q < fd_q);
  assign stat_o.qp_high   = (d_x > fd_x + span_x);
  assign stat_o.r_zero    = r_zero_q;
  assign stat_o.b_zero    = (b_q == '0);
  assign stat_o.scan_go   = (j_q < hi_q) && (j_q < cnt_q);
  assign stat_o.ts_ge     = (store_rd >= word_q.range_start);
  assign stat_o.p_go      = (j_q > lo_q);
  assign stat_o.j_in      = (j_q <= cnt_q);
  assign stat_o.ts_le     = (store_rd <= word_q.range_stop);

  // store read address
  always_comb begin
    case (op)
      DP_FD:        st_ra_full = cnt_q - CNT_W'(1);
      DP_FWD_FETCH: st_ra_full = i_q;
      DP_REV_FETCH: st_ra_full = i_q - CNT_W'(1);
      DP_QS_SCAN:   st_ra_full = j_q;
      DP_QP_SCAN:   st_ra_full = j_q - CNT_W'(1);
      default:      st_ra_full = '0;
    endcase
  end

  assign st_ra = st_ra_full[AW-1:0];
  assign st_wa = cnt_eff[AW-1:0];
  assign st_we = (op == DP_APPEND) && has_room;
  assign ft_ra = (op == DP_QS_LO) ? b_p1[DAW-1:0] : dsub[DAW-1:0];
  assign et_ra = (op == DP_QP_HI) ? b_m1[DAW-1:0] : b_clamp[DAW-1:0];
  assign ft_wa = k_q[DAW-1:0];
  assign et_wa = k_m1[DAW-1:0];
  assign ft_we = ((op == DP_FWD_STEP) && fwd_hit) || ((op == DP_FWD_FILL) && (k_q < span_q));
  assign ft_wd = (op == DP_FWD_STEP) ? i_q : cnt_q;
  assign et_we = ((op == DP_REV_STEP) && rev_hit) || ((op == DP_REV_FILL) && (k_q != '0));
  assign et_wd = (op == DP_REV_STEP) ? i_q : '0;

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[st_wa] <= word_q.timestamp;
    end
    store_rd <= store_mem[st_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ft_we) begin
      first_mem[ft_wa] <= ft_wd;
    end
    first_rd <= first_mem[ft_ra];
  end

  always_ff @(posedge clk_i) begin
    if (et_we) begin
      end_mem[et_wa] <= et_wd;
    end
    end_rd <= end_mem[et_ra];
  end

  always_comb begin
    cnt_d       = cnt_q;
    load_open_d = load_open_q;
    ovf_d       = ovf_q;
    built_d     = built_q;
    fetch_d     = 1'b0;
    word_d      = word_q;
    fd_d        = fd_q;
    span_d      = span_q;
    i_d         = i_q;
    k_d         = k_q;
    j_d         = j_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    b_d         = b_q;
    d_d         = d_q;
    r_zero_d    = r_zero_q;
    start_d     = start_q;
    stop_d      = stop_q;
    status_d    = status_q;
    out_d       = out_q;
    case (op)
      DP_CAPTURE: begin
        word_d   = in_word_i;
        start_d  = '0;
        stop_d   = '0;
        status_d = ST_OK;
      end
      DP_APPEND: begin
        // open a new load on its first word
        if (!load_open_q) begin
          ovf_d   = 1'b0;
          built_d = 1'b0;
        end
        if (has_room) begin
          cnt_d = cnt_eff + CNT_W'(1);
        end else begin
          cnt_d = cnt_eff;
          ovf_d = 1'b1;
        end
        load_open_d = !word_q.last_of_load;
      end
      DP_BLD_CHECK: begin
        if (bad_store) begin
          status_d = ST_STORE_OVF;
        end else begin
          fetch_d = 1'b1;
        end
      end
      DP_FD: begin
        fd_d    = div_day;
        fetch_d = 1'b1;
      end
      DP_LD: begin
        if (days_bad) begin
          status_d = ST_DAY_OVF;
        end else begin
          span_d = DW'(dv_x - fd_x + CMP_W'(1));
          i_d    = '0;
          k_d    = '0;
        end
      end
      DP_LATCH_DAY: begin
        d_d      = div_day;
        r_zero_d = (div_rem == '0);
      end
      DP_FWD_FETCH, DP_REV_FETCH: begin
        fetch_d = 1'b1;
      end
      DP_FWD_STEP: begin
        if (fwd_hit) begin
          k_d = k_q + DW'(1);
        end else begin
          i_d = i_q + CNT_W'(1);
        end
      end
      DP_FWD_FILL: begin
        if (k_q < span_q) begin
          k_d = k_q + DW'(1);
        end else begin
          i_d = cnt_q;
          k_d = span_q;
        end
      end
      DP_REV_STEP: begin
        if (rev_hit) begin
          k_d = k_m1;
        end else begin
          i_d = i_q - CNT_W'(1);
        end
      end
      DP_REV_FILL: begin
        if (k_q != '0) begin
          k_d = k_m1;
        end else begin
          built_d  = 1'b1;
          status_d = ST_OK;
        end
      end
      DP_DENY: begin
        status_d = ST_NOT_BUILT;
      end
      DP_QS_DEC: begin
        if (d_q < fd_q) begin
          start_d = '0;
        end else if (dsub_x >= span_x) begin
          start_d = cnt_q;
        end else begin
          b_d = DW'(dsub);
        end
      end
      DP_QS_LO: begin
        lo_d = first_rd;
        j_d  = first_rd;
        if (r_zero_q) begin
          start_d = first_rd;
        end
      end
      DP_QS_HI: begin
        hi_d = (b_p1 == span_q) ? cnt_q : first_rd;
      end
      DP_QS_SCAN: begin
        if (!((j_q < hi_q) && (j_q < cnt_q))) begin
          start_d = j_q;
        end
      end
      DP_QS_CMP: begin
        if (store_rd >= word_q.range_start) begin
          start_d = j_q;
        end else begin
          j_d = j_q + CNT_W'(1);
        end
      end
      DP_QP_DEC: begin
        if (d_x > fd_x + span_x) begin
          stop_d = cnt_q;
        end else if (d_q < fd_q) begin
          stop_d = '0;
        end else begin
          b_d = b_clamp;
        end
      end
      DP_QP_HI: begin
        if (r_zero_q) begin
          stop_d = end_rd;
        end else begin
          j_d = end_rd;
          if (b_q == '0) begin
            lo_d = '0;
          end
        end
      end
      DP_QP_LO: begin
        lo_d = end_rd;
      end
      DP_QP_SCAN: begin
        if (j_q > lo_q) begin
          // skip an index beyond the store without reading it
          if (!(j_q <= cnt_q)) begin
            j_d = j_q - CNT_W'(1);
          end
        end else begin
          stop_d = lo_q;
        end
      end
      DP_QP_CMP: begin
        if (store_rd <= word_q.range_stop) begin
          stop_d = j_q;
        end else begin
          j_d = j_q - CNT_W'(1);
        end
      end
      DP_EMIT: begin
        out_d.start_index = IDX_W'(start_q);
        out_d.stop_index  = IDX_W'(stop_q);
        out_d.status      = status_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      load_open_q <= 1'b0;
      ovf_q       <= 1'b0;
      built_q     <= 1'b0;
      fetch_q     <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      load_open_q <= load_open_d;
      ovf_q       <= ovf_d;
      built_q     <= built_d;
      fetch_q     <= fetch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q   <= word_d;
    fd_q     <= fd_d;
    span_q   <= span_d;
    i_q      <= i_d;
    k_q      <= k_d;
    j_q      <= j_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    b_q      <= b_d;
    d_q      <= d_d;
    r_zero_q <= r_zero_d;
    start_q  <= start_d;
    stop_q   <= stop_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign out_word_o = out_q;

endmodule

>>> hw/rtl/dbtri_ctrl.sv
// ----------------------------------------------------------------------------
// dbtri_ctrl
// Sequencer for load, table build and range query; owns the output valid.
// ----------------------------------------------------------------------------
module dbtri_ctrl import dbtri_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH,
    S_B_CHK, S_B_FD, S_B_LD,
    S_F_FETCH, S_F_WAIT, S_F_STEP, S_F_FILL,
    S_R_FETCH, S_R_WAIT, S_R_STEP, S_R_FILL,
    S_QS_WAIT, S_QS_DEC, S_QS_LO, S_QS_HI, S_QS_SCAN, S_QS_CMP,
    S_QP_DIV, S_QP_WAIT, S_QP_DEC, S_QP_HI, S_QP_LO, S_QP_SCAN, S_QP_CMP,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  dp_op_e op;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    op          = DP_NOP;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op      = DP_CAPTURE;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!stat_i.is_query) begin
          op      = DP_APPEND;
          state_d = stat_i.is_last ? S_B_CHK : S_IDLE;
        end else if (!stat_i.built) begin
          op      = DP_DENY;
          state_d = S_EMIT;
        end else begin
          op      = DP_QS_DIV;
          state_d = S_QS_WAIT;
        end
      end
      S_B_CHK: begin
        op      = DP_BLD_CHECK;
        state_d = stat_i.bad_store ? S_EMIT : S_B_FD;
      end
      S_B_FD: begin
        if (stat_i.day_valid) begin
          op      = DP_FD;
          state_d = S_B_LD;
        end
      end
      S_B_LD: begin
        if (stat_i.day_valid) begin
          op      = DP_LD;
          state_d = stat_i.days_bad ? S_EMIT : S_F_FETCH;
        end
      end
      S_F_FETCH: begin
        op      = DP_FWD_FETCH;
        state_d = S_F_WAIT;
      end
      S_F_WAIT: begin
        if (stat_i.day_valid) begin
          op      = DP_LATCH_DAY;
          state_d = S_F_STEP;
        end
      end
      S_F_STEP: begin
        op = DP_FWD_STEP;
        if (!stat_i.fwd_hit) begin
          state_d = stat_i.i_last ? S_F_FILL : S_F_FETCH;
        end
      end
      S_F_FILL: begin
        op = DP_FWD_FILL;
        if (stat_i.k_full) begin
          state_d = S_R_FETCH;
        end
      end
      S_R_FETCH: begin
        op      = DP_REV_FETCH;
        state_d = S_R_WAIT;
      end
      S_R_WAIT: begin
        if (stat_i.day_valid) begin
          op      = DP_LATCH_DAY;
          state_d = S_R_STEP;
        end
      end
      S_R_STEP: begin
        op = DP_REV_STEP;
        if (!stat_i.rev_hit) begin
          state_d = stat_i.i_first ? S_R_FILL : S_R_FETCH;
        end
      end
      S_R_FILL: begin
        op = DP_REV_FILL;
        if (stat_i.k_zero) begin
          state_d = S_EMIT;
        end
      end
      S_QS_WAIT: begin
        if (stat_i.day_valid) begin
          op      = DP_LATCH_DAY;
          state_d = S_QS_DEC;
        end
      end
      S_QS_DEC: begin
        op      = DP_QS_DEC;
        state_d = (stat_i.qs_low || stat_i.qs_high) ? S_QP_DIV : S_QS_LO;
      end
      S_QS_LO: begin
        op      = DP_QS_LO;
        state_d = stat_i.r_zero ? S_QP_DIV : S_QS_HI;
      end
      S_QS_HI: begin
        op      = DP_QS_HI;
        state_d = S_QS_SCAN;
      end
      S_QS_SCAN: begin
        op      = DP_QS_SCAN;
        state_d = stat_i.scan_go ? S_QS_CMP : S_QP_DIV;
      end
      S_QS_CMP: begin
        op      = DP_QS_CMP;
        state_d = stat_i.ts_ge ? S_QP_DIV : S_QS_SCAN;
      end
      S_QP_DIV: begin
        op      = DP_QP_DIV;
        state_d = S_QP_WAIT;
      end
      S_QP_WAIT: begin
        if (stat_i.day_valid) begin
          op      = DP_LATCH_DAY;
          state_d = S_QP_DEC;
        end
      end
      S_QP_DEC: begin
        op      = DP_QP_DEC;
        state_d = (stat_i.qp_high || stat_i.qp_low) ? S_EMIT : S_QP_HI;
      end
      S_QP_HI: begin
        op = DP_QP_HI;
        if (stat_i.r_zero) begin
          state_d = S_EMIT;
        end else begin
          state_d = stat_i.b_zero ? S_QP_SCAN : S_QP_LO;
        end
      end
      S_QP_LO: begin
        op      = DP_QP_LO;
        state_d = S_QP_SCAN;
      end
      S_QP_SCAN: begin
        op = DP_QP_SCAN;
        if (!stat_i.p_go) begin
          state_d = S_EMIT;
        end else if (stat_i.j_in) begin
          state_d = S_QP_CMP;
        end
      end
      S_QP_CMP: begin
        op      = DP_QP_CMP;
        state_d = stat_i.ts_le ? S_EMIT : S_QP_SCAN;
      end
      S_EMIT: begin
        // hold the result until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          op          = DP_EMIT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o.op    = op;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/day_bucketed_time_range_index.sv
// ----------------------------------------------------------------------------
// day_bucketed_time_range_index
// Sorted time store with per-day bucket tables and range lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) takes one word per
//   item. Load words append a timestamp; the load word flagged last_of_load
//   closes the load, builds the per-day first/end tables and returns one
//   status word. Query words return start and stop indexes for the range.
//   Output channel (out_valid_o / out_stall_i / out_word_o) is a single
//   output register; a new input word is taken while a result still waits.
//   Items are handled one at a time. In a build every stored entry passes
//   through the single store read port and the 3-stage day divider once
//   per pass (forward pass, then backward pass). A query compares entries
//   of the start and stop buckets through the same read port.
//   Reset empties the store and marks the tables unbuilt; queries before a
//   good build answer status 3. A stalled output holds its word, and the
//   block waits in its final state until the register frees up.
// ----------------------------------------------------------------------------
module day_bucketed_time_range_index import dbtri_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 4096,
  parameter int unsigned MAX_DAYS    = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: decides one datapath operation per cycle
  dbtri_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // store, day tables, divider and result register
  dbtri_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_DAYS    (MAX_DAYS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .stat_o     (stat),
    .out_word_o (out_word_o)
  );

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the day-bucketed time range index: directed table
// of loads and queries, then random load sessions with random queries, all
// checked against an in-bench model of the store and day tables.
// ----------------------------------------------------------------------------
module tb;
  import dbtri_pkg::*;

  localparam int unsigned NENT     = 4096;
  localparam int unsigned NDAYS    = 1024;
  localparam int unsigned DAY_LEN  = 86400;
  localparam int unsigned WDOG_MAX = 400000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  day_bucketed_time_range_index DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_word_o(out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Index model: mirror of the store, the day tables and the load state
  // ---------------------------------------------------------------------------
  logic [TS_W-1:0]  ts_mem [NENT];
  logic [IDX_W-1:0] day_lo_tbl [NDAYS];
  logic [IDX_W-1:0] day_hi_tbl [NDAYS];
  int unsigned n_stored, base_day, n_days;
  bit built_q, session_open, ovf_q;

  out_word_t expected_words[$];
  int unsigned n_fail, n_loads, n_queries, n_builds_ok, n_checked;

  function automatic int unsigned day_of(int unsigned t);
    return t / DAY_LEN;
  endfunction

  function automatic status_e build_index();
    int unsigned fd, ld, k;
    if (ovf_q || n_stored == 0) return ST_STORE_OVF;
    fd = day_of(ts_mem[0]);
    ld = day_of(ts_mem[n_stored-1]);
    if (ld < fd || ld - fd + 1 > NDAYS) return ST_DAY_OVF;
    base_day = fd;
    n_days = ld - fd + 1;
    k = 0;
    for (int unsigned i = 0; i < n_stored; i++)
      while (k < n_days && day_of(ts_mem[i]) >= fd + k) begin
        day_lo_tbl[k] = IDX_W'(i);
        k++;
      end
    while (k < n_days) begin
      day_lo_tbl[k] = IDX_W'(n_stored);
      k++;
    end
    k = n_days;
    for (int unsigned i = n_stored; i > 0; i--)
      while (k > 0 && day_of(ts_mem[i-1]) <= fd + k - 1) begin
        day_hi_tbl[k-1] = IDX_W'(i);
        k--;
      end
    while (k > 0) begin
      day_hi_tbl[k-1] = '0;
      k--;
    end
    built_q = 1'b1;
    return ST_OK;
  endfunction

  function automatic int unsigned lower_count(int unsigned s);
    int unsigned d, b, lo, hi, j;
    d = day_of(s);
    if (d < base_day) return 0;
    b = d - base_day;
    if (b >= n_days) return n_stored;
    lo = day_lo_tbl[b];
    if (s % DAY_LEN == 0) return lo;
    hi = (b + 1 == n_days) ? n_stored : day_lo_tbl[b+1];
    for (j = lo; j < hi && j < n_stored; j++)
      if (ts_mem[j] >= s) return j;
    return j;
  endfunction

  function automatic int unsigned upper_count(int unsigned s);
    int unsigned d, b, lo, hi;
    d = day_of(s);
    if (d > base_day + n_days) return n_stored;
    if (d < base_day) return 0;
    b = d - base_day;
    if (b > n_days - 1) b = n_days - 1;
    hi = day_hi_tbl[b];
    if (s % DAY_LEN == 0) return hi;
    lo = (b == 0) ? 0 : day_hi_tbl[b-1];
    for (int unsigned j = hi; j > lo; j--)
      if (j <= n_stored && ts_mem[j-1] <= s) return j;
    return lo;
  endfunction

  // Advance the model by one accepted word; queue its result if it makes one
  task automatic index_model_step(input in_word_t w);
    out_word_t r;
    r = '0;
    if (w.opcode == OPC_LOAD) begin
      n_loads++;
      if (!session_open) begin
        n_stored = 0;
        ovf_q = 1'b0;
        built_q = 1'b0;
        session_open = 1'b1;
      end
      if (n_stored < NENT) begin
        ts_mem[n_stored] = w.timestamp;
        n_stored++;
      end else begin
        ovf_q = 1'b1;
      end
      if (!w.last_of_load) return;
      session_open = 1'b0;
      r.status = build_index();
      if (r.status == ST_OK) n_builds_ok++;
    end else begin
      n_queries++;
      if (!built_q) begin
        r.status = ST_NOT_BUILT;
      end else begin
        r.start_index = IDX_W'(lower_count(w.range_start));
        r.stop_index  = IDX_W'(upper_count(w.range_stop));
        r.status      = ST_OK;
      end
    end
    expected_words.insert(expected_words.size(), r);
  endtask

  // ---------------------------------------------------------------------------
  // Output checker: compare each accepted result word with the oldest one due
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_word_o);
        n_fail++;
      end else begin
        out_word_t e;
        e = expected_words.pop_front();
        n_checked++;
        if (out_word_o.start_index !== e.start_index) begin
          $display("%0t: start_index expected %0d actual %0d", $time, e.start_index,
                   out_word_o.start_index);
          n_fail++;
        end
        if (out_word_o.stop_index !== e.stop_index) begin
          $display("%0t: stop_index expected %0d actual %0d", $time, e.stop_index,
                   out_word_o.stop_index);
          n_fail++;
        end
        if (out_word_o.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status,
                   out_word_o.status);
          n_fail++;
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on either side
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_MAX) begin
      $display("%0t: watchdog expired", $time);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall pattern: mostly random, phases of none, one long hold-off
  // ---------------------------------------------------------------------------
  bit hold_off_req;
  bit hold_off_done;
  initial begin
    int unsigned mode;
    mode = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        out_stall_i <= 1'b1;
        repeat (600) @(negedge clk_i);
        hold_off_done = 1'b1;
        out_stall_i <= 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  int unsigned burst_left;

  // Offer one word, hold it until taken, then advance the model
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_word_i  <= w;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    index_model_step(w);
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_words.size() != 0) @(negedge clk_i);
  endtask

  function automatic in_word_t load_word(int unsigned t, bit last);
    in_word_t w;
    w = '0;
    w.opcode       = OPC_LOAD;
    w.timestamp    = TS_W'(t);
    w.last_of_load = last;
    w.range_start  = TS_W'($urandom);
    w.range_stop   = TS_W'($urandom);
    return w;
  endfunction

  function automatic in_word_t query_word(int unsigned a, int unsigned b);
    in_word_t w;
    w = '0;
    w.opcode       = OPC_QUERY;
    w.timestamp    = TS_W'($urandom);
    w.last_of_load = 1'($urandom_range(0, 1));
    w.range_start  = TS_W'(a);
    w.range_stop   = TS_W'(b);
    return w;
  endfunction

  // Pick a query bound, mostly near the loaded data: midnights, stored times, edges
  function automatic int unsigned pick_bound(int unsigned lo_t, int unsigned hi_t);
    int unsigned d;
    case ($urandom_range(0, 7))
      0: return $urandom & 32'h7FFF_FFFF;
      1: return ((lo_t / DAY_LEN) + $urandom_range(0, 4) - 1) * DAY_LEN;
      2: return ((hi_t / DAY_LEN) + $urandom_range(0, 2)) * DAY_LEN;
      3: return (n_stored > 0) ? ts_mem[$urandom_range(0, n_stored - 1)] : lo_t;
      4: return (n_stored > 0) ? ts_mem[$urandom_range(0, n_stored - 1)] + 1 : lo_t;
      5: return (n_stored > 0) ? ts_mem[$urandom_range(0, n_stored - 1)] - 1 : lo_t;
      default: begin
        d = $urandom_range(lo_t > DAY_LEN ? lo_t - DAY_LEN : 0, hi_t + 2 * DAY_LEN);
        return d & 32'h7FFF_FFFF;
      end
    endcase
  endfunction

  // Directed table: opcode, timestamp or range_start, last / range_stop,
  // and an expected word where it is obvious (check flag set)
  typedef struct {
    bit          is_query;
    int unsigned a;
    int unsigned b;
    bit          last;
    bit          chk;
    out_word_t   want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic dir_row_t row(bit q, int unsigned a, int unsigned b, bit l,
                                   bit c, int unsigned s0, int unsigned s1,
                                   status_e st);
    dir_row_t r;
    r.is_query = q; r.a = a; r.b = b; r.last = l; r.chk = c;
    r.want.start_index = IDX_W'(s0); r.want.stop_index = IDX_W'(s1);
    r.want.status = st;
    return r;
  endfunction

  task automatic add_row(input dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endtask

  initial begin
    in_word_t    w;
    int unsigned t, n, lo_t, q_n, base;
    localparam int unsigned TMAX = 32'h7FFF_FFFF;

    // Directed: query before build, extremes, midnights, day-after-last rule
    add_row(row(1, 0, TMAX, 0, 1, 0, 0, ST_NOT_BUILT));
    add_row(row(0, 0, 0, 0, 0, 0, 0, ST_OK));
    add_row(row(0, 86399, 0, 0, 0, 0, 0, ST_OK));
    add_row(row(0, 86400, 0, 0, 0, 0, 0, ST_OK));
    add_row(row(0, 3 * 86400 + 5, 0, 0, 0, 0, 0, ST_OK));
    add_row(row(0, 3 * 86400 + 5, 0, 1, 1, 0, 0, ST_OK));
    add_row(row(1, 0, 0, 0, 1, 0, 2, ST_OK));
    add_row(row(1, TMAX, TMAX, 0, 1, 5, 5, ST_OK));
    add_row(row(1, 86400, 86400, 0, 0, 0, 0, ST_OK));
    add_row(row(1, 2 * 86400, 2 * 86400, 0, 0, 0, 0, ST_OK));
    add_row(row(1, 2 * 86400 + 7, 3 * 86400 + 4, 0, 0, 0, 0, ST_OK));
    add_row(row(1, 3 * 86400 + 6, 4 * 86400 + 9, 0, 0, 0, 0, ST_OK));
    add_row(row(1, 86399, 86399, 0, 0, 0, 0, ST_OK));
    // New load far in time; single-entry store at the top of the range
    add_row(row(0, TMAX, 0, 1, 1, 0, 0, ST_OK));
    add_row(row(1, 0, 0, 0, 1, 0, 0, ST_OK));
    add_row(row(1, TMAX, TMAX, 0, 1, 0, 1, ST_OK));
    // Too many days, then the query sees an unbuilt index
    add_row(row(0, 0, 0, 0, 0, 0, 0, ST_OK));
    add_row(row(0, NDAYS * DAY_LEN, 0, 1, 1, 0, 0, ST_DAY_OVF));
    add_row(row(1, 5, 5, 0, 1, 0, 0, ST_NOT_BUILT));
    // Decreasing day order
    add_row(row(0, 5 * DAY_LEN, 0, 0, 0, 0, 0, ST_OK));
    add_row(row(0, 100, 0, 1, 1, 0, 0, ST_DAY_OVF));
    // Exactly MAX_DAYS span is fine
    add_row(row(0, 0, 0, 0, 0, 0, 0, ST_OK));
    add_row(row(0, NDAYS * DAY_LEN - 1, 0, 1, 1, 0, 0, ST_OK));
    add_row(row(1, 0, TMAX, 0, 1, 0, 2, ST_OK));

    burst_left = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_query) w = query_word(dir_rows[i].a, dir_rows[i].b);
      else w = load_word(dir_rows[i].a, dir_rows[i].last);
      send_word(w);
      if (dir_rows[i].chk && expected_words.size() != 0 &&
          expected_words[$] != dir_rows[i].want) begin
        $display("%0t: table row %0d model gives %h, table %h", $time, i,
                 expected_words[$], dir_rows[i].want);
        n_fail++;
      end
    end
    drain_results();

    // Random sessions: mostly sorted loads over a few days, then queries
    for (int unsigned sess = 0; n_loads + n_queries < 750 && sess < 200; sess++) begin
      n = $urandom_range(1, 24);
      base = $urandom_range(0, 3) == 0 ? ($urandom & TMAX) - 40 * DAY_LEN
                                       : $urandom_range(0, 200) * DAY_LEN;
      base = base & TMAX;
      if (base > TMAX - 20 * DAY_LEN) base = TMAX - 20 * DAY_LEN;
      t = base + $urandom_range(0, DAY_LEN);
      lo_t = t;
      for (int unsigned i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0: t = t;
          1: t = (t / DAY_LEN + $urandom_range(1, 3)) * DAY_LEN;
          2: t = t + $urandom_range(1, 3) * DAY_LEN;
          3: if ($urandom_range(0, 3) == 0) t = t - $urandom_range(0, 2 * DAY_LEN);
          default: t = t + $urandom_range(1, 20000);
        endcase
        send_word(load_word(t & TMAX, i == n - 1));
      end
      if (sess == 10) hold_off_req = 1'b1;
      q_n = $urandom_range(4, 16);
      for (int unsigned i = 0; i < q_n; i++)
        send_word(query_word(pick_bound(lo_t, t), pick_bound(lo_t, t)));
      if ($urandom_range(0, 3) == 0) drain_results();
    end

    drain_results();
    repeat (50) @(negedge clk_i);
    $display("Covered %0d loads and %0d queries, %0d good builds, %0d results checked.",
             n_loads, n_queries, n_builds_ok, n_checked);
    if (n_fail == 0 && expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (expected_words.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, expected_words.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/dbtri_pkg.sv
hw/rtl/dbtri_day_div.sv
hw/rtl/dbtri_datapath.sv
hw/rtl/dbtri_ctrl.sv
hw/rtl/day_bucketed_time_range_index.sv
sim/tb.sv
